// File: rtl/core/ira_pkg.sv
package ira_pkg;

    localparam int RADIX_W   = 6;
    localparam int CHAR_W    = 7;
    localparam int DIV_STEPS = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_MAX   = 6'd9;
    localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ZERO,
        S_DIV,
        S_SIGN,
        S_READ,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic load;
    } div_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [RADIX_W-1:0] digit;
        logic               quot_zero;
    } div_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_MAX)
        begin
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        else
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

// File: rtl/core/ira_ram.sv
module ira_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ira_div.sv
module ira_div
    import ira_pkg::*;
#(
    parameter int MAG_W = 63
) (
    input  logic               clk,
    input  logic               rst_n,
    input  div_ctrl_t          ctrl,
    input  logic [MAG_W-1:0]   dividend,
    input  logic [RADIX_W-1:0] radix,
    output div_status_t        status
);

    localparam int CHUNKS = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_W  = CHUNKS * DIV_STEPS;
    localparam int CNT_W  = $clog2(CHUNKS + 1);

    logic [PAD_W-1:0]     work_reg, work_next;
    logic [RADIX_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [RADIX_W:0]     rem_step;
    logic [DIV_STEPS-1:0] qbits;

    // Long division of the top bits of the work word, one bit per step.
    always_comb
    begin
        rem_step = {1'b0, rem_reg};
        qbits    = '0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            rem_step = {rem_step[RADIX_W-1:0], work_reg[PAD_W-1-i]};
            if (rem_step >= {1'b0, radix})
            begin
                rem_step                = rem_step - {1'b0, radix};
                qbits[DIV_STEPS-1-i] = 1'b1;
            end
        end
    end

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            if (ctrl.load)
            begin
                work_next = PAD_W'(dividend);
            end
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = (work_reg << DIV_STEPS) | PAD_W'(qbits);
            rem_next  = rem_step[RADIX_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CHUNKS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign status.done      = done_reg;
    assign status.digit     = rem_reg;
    assign status.quot_zero = (work_reg == '0);

endmodule

// File: rtl/core/integer_to_radix_ascii.sv
// Sequence: a load state and a check state, then DIV_STEPS-bit chunks of the magnitude
// go through the divider, one pass per digit, the digits going into the digit memory.
// Each digit is read back from the digit memory in a read and an emit state, the sign
// going out before them; one item is worked on at a time.
// Reset sets the radix to ten, empties the output register and idles the sequencer;
// the digit memory is not cleared, since every entry is written before it is read.
module integer_to_radix_ascii
    import ira_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [RADIX_W-1:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [63:0]        value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  character,
    output logic               last
);

    localparam int MAG_W  = VALUE_BITS - 1;
    localparam int ADDR_W = $clog2(VALUE_BITS);

    state_t              state_reg, state_next;
    logic [RADIX_W-1:0]  radix_reg;
    logic [RADIX_W-1:0]  radix_eff;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [ADDR_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   character_reg, character_next;
    logic                last_reg, last_next;

    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] v_abs;
    logic                  slot_free;
    logic                  wr_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [RADIX_W-1:0]    rd_data;
    div_ctrl_t             div_ctrl;
    div_status_t           div_status;

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            radix_eff = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            radix_eff = RADIX_MAX;
        end
        else
        begin
            radix_eff = radix_reg;
        end
    end

    assign v         = value[VALUE_BITS-1:0];
    assign v_abs     = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    assign slot_free = !out_valid_reg || out_ready;
    assign rd_addr   = idx_reg - 1'b1;
    assign wr_en     = (state_reg == S_DIV) && div_status.done;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        character_next = character_reg;
        last_next      = last_reg;
        div_ctrl       = '0;
        in_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    neg_next = v[VALUE_BITS-1];
                    // The most negative value saturates to the largest magnitude.
                    if (v_abs[VALUE_BITS-1])
                    begin
                        mag_next = '1;
                    end
                    else
                    begin
                        mag_next = v_abs[MAG_W-1:0];
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                count_next = '0;
                if (mag_reg == '0)
                begin
                    state_next = S_ZERO;
                end
                else
                begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.load  = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_ZERO:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    character_next = CHAR_ZERO;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    count_next = count_reg + 1'b1;
                    if (div_status.quot_zero)
                    begin
                        idx_next   = count_reg + 1'b1;
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        div_ctrl.start = 1'b1;
                    end
                end
            end
            S_SIGN:
            begin
                if (!neg_reg)
                begin
                    state_next = S_READ;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    character_next = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    character_next = digit_char(rd_data);
                    last_next      = (idx_reg == ADDR_W'(1));
                    idx_next       = idx_reg - 1'b1;
                    state_next     = (idx_reg == ADDR_W'(1)) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radix_reg     <= RADIX_RESET;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                radix_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    ira_div #(
        .MAG_W (MAG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (mag_reg),
        .radix    (radix_eff),
        .status   (div_status)
    );

    ira_ram #(
        .WIDTH (RADIX_W),
        .DEPTH (VALUE_BITS)
    ) u_digit_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg),
        .wr_data (div_status.digit),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide phase");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (div_status.digit < radix_eff))
        else $error("stored digit not below the radix");

    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (idx_reg != '0))
        else $error("character emitted with no digit left");

    a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !div_status.done) |=> !$past(div_ctrl.start))
        else $error("divider restarted while busy");

endmodule

// File: bench/radix_ascii_checker.sv
`timescale 1ns / 1ps

module radix_ascii_checker
    import ira_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [RADIX_W-1:0] cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [63:0]        value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [CHAR_W-1:0]  character,
    input  logic               last,
    output int                 chars_owed,
    output int                 mismatch_count
);

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              final_char;
    } ascii_item_t;

    ascii_item_t        owed_chars[$];
    ascii_item_t        want;
    logic [RADIX_W-1:0] radix_copy;
    int                 step_errors;

    function automatic void spell_value(input logic [63:0] raw);
        logic [63:0]        mask;
        logic [63:0]        top;
        logic [63:0]        v;
        logic [63:0]        mag;
        logic [63:0]        base;
        logic [RADIX_W-1:0] digits[64];
        logic [RADIX_W-1:0] d;
        ascii_item_t        item;
        int                 n;
        mask = {64{1'b1}} >> (64 - VALUE_BITS);
        top  = 64'd1 << (VALUE_BITS - 1);
        v    = raw & mask;
        base = 64'(radix_copy);
        if (radix_copy < RADIX_MIN)
        begin
            base = 64'(RADIX_MIN);
        end
        if (radix_copy > RADIX_MAX)
        begin
            base = 64'(RADIX_MAX);
        end
        if ((v & top) != 64'd0)
        begin
            mag = (~v + 64'd1) & mask;
            if (mag == top)
            begin
                mag = top - 64'd1;
            end
            item.code       = CHAR_MINUS;
            item.final_char = 1'b0;
            owed_chars.push_back(item);
        end
        else
        begin
            mag = v;
        end
        if (mag == 64'd0)
        begin
            item.code       = CHAR_ZERO;
            item.final_char = 1'b1;
            owed_chars.push_back(item);
            return;
        end
        n = 0;
        while (mag != 64'd0 && n < 64)
        begin
            digits[n] = RADIX_W'(mag % base);
            n++;
            mag = mag / base;
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            d = digits[i];
            if (d > DIGIT_MAX)
            begin
                item.code = CHAR_A + CHAR_W'(d - DIGIT_TEN);
            end
            else
            begin
                item.code = CHAR_ZERO + CHAR_W'(d);
            end
            item.final_char = (i == 0);
            owed_chars.push_back(item);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_copy     <= RADIX_RESET;
            owed_chars.delete();
            chars_owed     <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            step_errors = 0;
            if (cfg_we)
            begin
                radix_copy <= cfg_wdata;
            end
            if (out_valid && out_ready)
            begin
                if (owed_chars.size() == 0)
                begin
                    $error("unexpected item: character %0d, last %0d", character, last);
                    step_errors++;
                end
                else
                begin
                    want = owed_chars.pop_front();
                    if (character !== want.code)
                    begin
                        $error("character: expected %0d, got %0d", want.code, character);
                        step_errors++;
                    end
                    if (last !== want.final_char)
                    begin
                        $error("last: expected %0d, got %0d", want.final_char, last);
                        step_errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                spell_value(value);
            end
            chars_owed     <= owed_chars.size();
            mismatch_count <= mismatch_count + step_errors;
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import ira_pkg::*;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [RADIX_W-1:0] cfg_wdata = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [63:0]        value     = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CHAR_W-1:0]  character;
    logic               last;
    int                 chars_owed;
    int                 mismatch_count;
    int                 burst_left = 4;
    int                 ready_mode = 0;
    int                 mode_left  = 0;

    integer_to_radix_ascii #(
        .VALUE_BITS(64)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .character(character),
        .last     (last)
    );

    radix_ascii_checker #(
        .VALUE_BITS(64)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .character     (character),
        .last          (last),
        .chars_owed    (chars_owed),
        .mismatch_count(mismatch_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(16, 200);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((mode_left % 7) < 5);
        endcase
    end

    task automatic push_value(input logic [63:0] v);
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chars_owed != 0)
        begin
            @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [63:0] random_value(input logic [RADIX_W-1:0] r);
        logic [63:0] v;
        logic [63:0] p;
        logic [63:0] b;
        int          pick;
        b = 64'(r);
        if (r < RADIX_MIN)
        begin
            b = 64'(RADIX_MIN);
        end
        if (r > RADIX_MAX)
        begin
            b = 64'(RADIX_MAX);
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: v = {$urandom, $urandom};
            3, 4: v = 64'($urandom_range(0, 50));
            5: v = 64'($urandom);
            6: v = {{32{1'b1}}, $urandom};
            7:
            begin
                p = 64'd1;
                repeat ($urandom_range(0, 63))
                begin
                    if (p <= 64'h7FFF_FFFF_FFFF_FFFF / b)
                    begin
                        p = p * b;
                    end
                end
                v = p - 64'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
            8:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
                end
                else
                begin
                    v = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
                end
            end
            default: v = -64'($urandom_range(1, 50));
        endcase
        return v;
    endfunction

    initial
    begin
        static logic [RADIX_W-1:0] radix_plan[] = '{2, 36, 16, 0, 63, 37, 1, 10, 8, 3, 35, 21};
        logic [RADIX_W-1:0] r;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset radix is ten.
        push_value(64'd0);
        push_value(64'd1);
        push_value(-64'd1);
        push_value(64'd9);
        push_value(64'd10);
        push_value(-64'd10);
        push_value(64'h7FFF_FFFF_FFFF_FFFF);
        push_value(64'h8000_0000_0000_0001);
        push_value(64'h8000_0000_0000_0000);

        write_radix(6'd36);
        push_value(64'd35);
        push_value(64'd36);
        push_value(-64'd35);
        push_value(64'h7FFF_FFFF_FFFF_FFFF);

        write_radix(6'd2);
        push_value(64'h7FFF_FFFF_FFFF_FFFF);
        push_value(64'h8000_0000_0000_0000);
        push_value(64'd1);
        push_value(64'd0);

        // Out-of-range radix settings saturate to two and thirty-six.
        write_radix(6'd0);
        push_value(64'd5);
        write_radix(6'd63);
        push_value(64'd1295);
        write_radix(6'd1);
        push_value(-64'd6);

        foreach (radix_plan[ph])
        begin
            write_radix(radix_plan[ph]);
            for (int k = 0; k < 34; k++)
            begin
                if (k == 17)
                begin
                    settle();
                end
                push_value(random_value(radix_plan[ph]));
            end
        end

        repeat (2)
        begin
            r = RADIX_W'($urandom_range(0, 63));
            write_radix(r);
            repeat (25) push_value(random_value(r));
        end

        settle();
        repeat (700) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
